FILE: src/ptp_sode_pkg.sv
// shared types, constants and arithmetic helpers for the ptp offset/delay engine
package ptp_sode_pkg;

	localparam logic [15:0] SYNC_PORT_RESET = 16'd1234;
	localparam logic [7:0] CODE_RESYNC = 8'h66;
	localparam logic [7:0] CODE_DELAY_REQ = 8'h12;
	localparam logic signed [31:0] NS_WRAP = 32'sd1000000000;

	localparam logic [1:0] STEP_IDLE = 2'd0;
	localparam logic [1:0] STEP_RX = 2'd1;
	localparam logic [1:0] STEP_TX = 2'd2;
	localparam logic [1:0] STEP_ADJ = 2'd3;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] n;
	} pair_t;

	typedef struct packed {
		logic [15:0] source_port;
		logic signed [31:0] seq_tag;
		logic signed [31:0] word_low;
		logic signed [31:0] word_high;
		logic signed [31:0] rx_sec;
		logic signed [31:0] rx_nsec;
		logic signed [31:0] tx_sec;
		logic signed [31:0] tx_nsec;
	} msg_t;

	typedef struct packed {
		logic reply_valid;
		logic [7:0] reply_code;
		logic adjust_valid;
		logic signed [31:0] offset_sec;
		logic signed [31:0] offset_nsec;
		logic signed [31:0] delay_sec;
		logic signed [31:0] delay_nsec;
	} res_t;

	// sum or difference of two sec/nsec pairs with sign normalization
	function automatic pair_t combine(pair_t a, pair_t b, logic sub);
		pair_t r;
		logic signed [31:0] s;
		logic signed [31:0] n;
		s = sub ? a.s - b.s : a.s + b.s;
		n = sub ? a.n - b.n : a.n + b.n;
		r.s = s;
		r.n = n;
		if (s < 0 && n > 0) begin
			r.s = s + 32'sd1;
			r.n = NS_WRAP - n;
			if (r.s == 32'sd0) begin
				r.n = -r.n;
			end
		end else if (s > 0 && n < 0) begin
			r.s = s - 32'sd1;
			r.n = n + NS_WRAP;
		end
		return r;
	endfunction

	function automatic pair_t sign_nsec(pair_t t);
		pair_t r;
		r = t;
		if (t.s < 0) begin
			r.n = -t.n;
		end
		return r;
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [31:0] half(logic signed [31:0] v);
		logic signed [31:0] adj;
		adj = v + $signed({31'b0, v[31]});
		return adj >>> 1;
	endfunction

endpackage

FILE: src/ptp_sode_if.sv
// request channel interfaces: received message in, reply/adjust result out
interface ptp_sode_msg_if;
	logic valid;
	logic ready;
	logic [15:0] source_port;
	logic signed [31:0] seq_tag;
	logic signed [31:0] word_low;
	logic signed [31:0] word_high;
	logic signed [31:0] rx_sec;
	logic signed [31:0] rx_nsec;
	logic signed [31:0] tx_sec;
	logic signed [31:0] tx_nsec;

	modport source (
		output valid, source_port, seq_tag, word_low, word_high,
		output rx_sec, rx_nsec, tx_sec, tx_nsec,
		input ready
	);
	modport sink (
		input valid, source_port, seq_tag, word_low, word_high,
		input rx_sec, rx_nsec, tx_sec, tx_nsec,
		output ready
	);
endinterface

interface ptp_sode_res_if;
	logic valid;
	logic ready;
	logic reply_valid;
	logic [7:0] reply_code;
	logic adjust_valid;
	logic signed [31:0] offset_sec;
	logic signed [31:0] offset_nsec;
	logic signed [31:0] delay_sec;
	logic signed [31:0] delay_nsec;

	modport source (
		output valid, reply_valid, reply_code, adjust_valid,
		output offset_sec, offset_nsec, delay_sec, delay_nsec,
		input ready
	);
	modport sink (
		input valid, reply_valid, reply_code, adjust_valid,
		input offset_sec, offset_nsec, delay_sec, delay_nsec,
		output ready
	);
endinterface

FILE: src/ptp_slave_offset_delay_engine_top.sv
// top level of the ptp two-step offset and delay engine
// a message is held in the input register, then its result in the result register
// throughput: one message per cycle via both registers while res.ready is high
// each message passes the sequencer and offset/delay arithmetic combinationally
// reset: step counter idle, sync port 1234, both stages empty
module ptp_slave_offset_delay_engine_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	ptp_sode_msg_if.sink msg,
	ptp_sode_res_if.source res
);
	import ptp_sode_pkg::*;

	logic valid_s1;
	logic adv;
	logic free;
	msg_t item_s1;
	res_t res_d;

	assign adv = valid_s1 && free;

	ptp_sode_in u_in (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.adv(adv),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	ptp_sode_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.adv(adv),
		.item(item_s1),
		.res_d(res_d)
	);

	ptp_sode_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv),
		.res_d(res_d),
		.free(free),
		.res(res)
	);

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res.valid)
		else $error("result register not filled after a pass");

	a_reply_xor_adjust: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.reply_valid && res.adjust_valid))
		else $error("reply and adjust both set");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.reply_valid) |-> (res.reply_code == 8'd0))
		else $error("reply code set without reply");

	a_adjust_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.adjust_valid) |-> (res.offset_sec == 32'sd0
			&& res.delay_nsec == 32'sd0))
		else $error("adjust fields set without adjust");
endmodule

FILE: src/ptp_sode_in.sv
// input register stage for incoming message requests
module ptp_sode_in (
	input logic clk,
	input logic arst_n,
	ptp_sode_msg_if.sink msg,
	input logic adv,
	output logic valid_s1,
	output ptp_sode_pkg::msg_t item_s1
);
	import ptp_sode_pkg::*;

	logic take;

	assign msg.ready = !valid_s1 || adv;
	assign take = msg.valid && msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.source_port <= msg.source_port;
			item_s1.seq_tag <= msg.seq_tag;
			item_s1.word_low <= msg.word_low;
			item_s1.word_high <= msg.word_high;
			item_s1.rx_sec <= msg.rx_sec;
			item_s1.rx_nsec <= msg.rx_nsec;
			item_s1.tx_sec <= msg.tx_sec;
			item_s1.tx_nsec <= msg.tx_nsec;
		end
	end
endmodule

FILE: src/ptp_sode_seq.sv
// step sequencer, latched timestamps and offset/delay arithmetic
module ptp_sode_seq (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	input logic adv,
	input ptp_sode_pkg::msg_t item,
	output ptp_sode_pkg::res_t res_d
);
	import ptp_sode_pkg::*;

	logic [15:0] sync_port_q;
	logic [1:0] step_q;
	logic [1:0] step_d;
	logic [1:0] step_nx;
	pair_t t2_q;
	pair_t t3_q;
	pair_t d1_q;
	pair_t d1_d;
	pair_t t1;
	pair_t t4;
	pair_t rx;
	pair_t tx;
	pair_t d2;
	pair_t off;
	pair_t dly;
	logic hit;
	logic tag_ok;
	logic lat_rx;
	logic lat_tx;

	assign step_nx = step_q + 2'd1;
	assign hit = item.source_port == sync_port_q;
	assign tag_ok = item.seq_tag == $signed({30'b0, step_nx});

	always_comb begin
		t1.s = item.word_high;
		t1.n = item.word_low;
		t4 = t1;
		rx.s = item.rx_sec;
		rx.n = item.rx_nsec;
		tx.s = item.tx_sec;
		tx.n = item.tx_nsec;
		// t2 - t1 is formed once t1 arrives
		d1_d = sign_nsec(combine(t2_q, t1, 1'b1));
		d2 = sign_nsec(combine(t4, t3_q, 1'b1));
		off = combine(d2, d1_q, 1'b1);
		dly = combine(d1_q, d2, 1'b0);
	end

	always_comb begin
		res_d = '0;
		step_d = step_q;
		lat_rx = 1'b0;
		lat_tx = 1'b0;
		if (hit) begin
			if (!tag_ok) begin
				res_d.reply_valid = 1'b1;
				res_d.reply_code = CODE_RESYNC;
				step_d = STEP_IDLE;
			end else begin
				unique case (step_nx)
					STEP_RX: begin
						lat_rx = 1'b1;
						step_d = STEP_RX;
					end
					STEP_TX: begin
						lat_tx = 1'b1;
						step_d = STEP_TX;
						res_d.reply_valid = 1'b1;
						res_d.reply_code = CODE_DELAY_REQ;
					end
					default: begin
						step_d = STEP_IDLE;
						res_d.adjust_valid = 1'b1;
						res_d.offset_sec = half(off.s);
						res_d.offset_nsec = half(off.n);
						res_d.delay_sec = half(dly.s);
						res_d.delay_nsec = half(dly.n);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_port_q <= SYNC_PORT_RESET;
			step_q <= STEP_IDLE;
		end else begin
			if (cfg_wr_en) begin
				sync_port_q <= cfg_wr_data;
			end
			if (adv) begin
				step_q <= step_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && lat_rx) begin
			t2_q <= rx;
		end
		if (adv && lat_tx) begin
			t3_q <= tx;
			d1_q <= d1_d;
		end
	end
endmodule

FILE: src/ptp_sode_out.sv
// result register driving the reply/adjust request channel
module ptp_sode_out (
	input logic clk,
	input logic arst_n,
	input logic load,
	input ptp_sode_pkg::res_t res_d,
	output logic free,
	ptp_sode_res_if.source res
);
	import ptp_sode_pkg::*;

	logic valid_q;
	res_t data_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_d;
		end
	end

	assign res.valid = valid_q;
	assign res.reply_valid = data_q.reply_valid;
	assign res.reply_code = data_q.reply_code;
	assign res.adjust_valid = data_q.adjust_valid;
	assign res.offset_sec = data_q.offset_sec;
	assign res.offset_nsec = data_q.offset_nsec;
	assign res.delay_sec = data_q.delay_sec;
	assign res.delay_nsec = data_q.delay_nsec;
endmodule

FILE: tb/ptp_sode_checker.sv
// checker: watches both request channels, predicts each result and compares it
`timescale 1ns / 100ps

module ptp_sode_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	ptp_sode_msg_if msg,
	ptp_sode_res_if res,
	output int fail_count,
	output int in_flight
);
	import ptp_sode_pkg::*;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] n;
	} span_t;

	logic [15:0] port_q = SYNC_PORT_RESET;
	logic [1:0] step_q = STEP_IDLE;
	span_t t1 = '0;
	span_t t2 = '0;
	span_t t3 = '0;
	res_t reply_adjust_q[$];
	int errs = 0;

	assign fail_count = errs;

	function automatic span_t span_join(span_t a, span_t b, bit minus);
		span_t r;
		if (minus) begin
			r.s = a.s - b.s;
			r.n = a.n - b.n;
		end else begin
			r.s = a.s + b.s;
			r.n = a.n + b.n;
		end
		if (r.s < 0 && r.n > 0) begin
			r.s = r.s + 32'sd1;
			r.n = (r.s == 0) ? r.n - NS_WRAP : NS_WRAP - r.n;
		end else if (r.s > 0 && r.n < 0) begin
			r.s = r.s - 32'sd1;
			r.n = r.n + NS_WRAP;
		end
		return r;
	endfunction

	function automatic span_t nsec_follow_sign(span_t d);
		span_t r;
		r = d;
		if (d.s < 0) begin
			r.n = -d.n;
		end
		return r;
	endfunction

	function automatic res_t predict_sync_result(msg_t m);
		res_t r;
		span_t t4;
		span_t d_fwd;
		span_t d_back;
		span_t off;
		span_t dly;
		r = '0;
		if (m.source_port != port_q) begin
			return r;
		end
		step_q = step_q + 2'd1;
		if (m.seq_tag != {30'b0, step_q}) begin
			r.reply_valid = 1'b1;
			r.reply_code = CODE_RESYNC;
			step_q = STEP_IDLE;
		end else if (step_q == STEP_RX) begin
			t2.s = m.rx_sec;
			t2.n = m.rx_nsec;
		end else if (step_q == STEP_TX) begin
			t1.s = m.word_high;
			t1.n = m.word_low;
			t3.s = m.tx_sec;
			t3.n = m.tx_nsec;
			r.reply_valid = 1'b1;
			r.reply_code = CODE_DELAY_REQ;
		end else begin
			t4.s = m.word_high;
			t4.n = m.word_low;
			d_fwd = nsec_follow_sign(span_join(t2, t1, 1'b1));
			d_back = nsec_follow_sign(span_join(t4, t3, 1'b1));
			off = span_join(d_back, d_fwd, 1'b1);
			dly = span_join(d_fwd, d_back, 1'b0);
			r.adjust_valid = 1'b1;
			r.offset_sec = off.s / 2;
			r.offset_nsec = off.n / 2;
			r.delay_sec = dly.s / 2;
			r.delay_nsec = dly.n / 2;
			step_q = STEP_IDLE;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		msg_t m;
		if (!arst_n) begin
			port_q = SYNC_PORT_RESET;
			step_q = STEP_IDLE;
			t1 = '0;
			t2 = '0;
			t3 = '0;
			reply_adjust_q.delete();
			in_flight <= 0;
		end else begin
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				if (reply_adjust_q.size() == 0) begin
					$error("result request with nothing expected");
					errs++;
				end else begin
					want = reply_adjust_q.pop_front();
					check_field("reply_valid", want.reply_valid, res.reply_valid);
					check_field("reply_code", want.reply_code, res.reply_code);
					check_field("adjust_valid", want.adjust_valid, res.adjust_valid);
					check_field("offset_sec", want.offset_sec, res.offset_sec);
					check_field("offset_nsec", want.offset_nsec, res.offset_nsec);
					check_field("delay_sec", want.delay_sec, res.delay_sec);
					check_field("delay_nsec", want.delay_nsec, res.delay_nsec);
				end
			end
			if (msg.valid === 1'b1 && msg.ready === 1'b1) begin
				m.source_port = msg.source_port;
				m.seq_tag = msg.seq_tag;
				m.word_low = msg.word_low;
				m.word_high = msg.word_high;
				m.rx_sec = msg.rx_sec;
				m.rx_nsec = msg.rx_nsec;
				m.tx_sec = msg.tx_sec;
				m.tx_nsec = msg.tx_nsec;
				reply_adjust_q.push_back(predict_sync_result(m));
			end
			if (cfg_wr_en) begin
				port_q = cfg_wr_data;
			end
			in_flight <= reply_adjust_q.size();
		end
	end

endmodule

FILE: tb/ptp_slave_offset_delay_engine_top_tb.sv
// testbench top: clock, reset, message stimulus, port settings and verdict
`timescale 1ns / 100ps

module ptp_slave_offset_delay_engine_top_tb;
	import ptp_sode_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [15:0] cfg_wr_data;
	int fail_count;
	int in_flight;
	int idle_pct = 0;
	int stall_pct = 0;
	logic [15:0] cur_port = SYNC_PORT_RESET;

	ptp_sode_msg_if msg_ch();
	ptp_sode_res_if res_ch();

	ptp_slave_offset_delay_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.msg(msg_ch),
		.res(res_ch)
	);

	ptp_sode_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.msg(msg_ch),
		.res(res_ch),
		.fail_count(fail_count),
		.in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4: return NS_WRAP;
			default: return -NS_WRAP;
		endcase
	endfunction

	function automatic logic [31:0] rand_stamp(bit nsec_part);
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return corner_word();
			default: return nsec_part ? $urandom_range(0, 999_999_999) : $urandom_range(0, 40) - 20;
		endcase
	endfunction

	task automatic push_msg(input logic [15:0] port, input logic signed [31:0] tag, wlo, whi,
			rxs, rxn, txs, txn);
		msg_ch.valid <= 1'b1;
		msg_ch.source_port <= port;
		msg_ch.seq_tag <= tag;
		msg_ch.word_low <= wlo;
		msg_ch.word_high <= whi;
		msg_ch.rx_sec <= rxs;
		msg_ch.rx_nsec <= rxn;
		msg_ch.tx_sec <= txs;
		msg_ch.tx_nsec <= txn;
		@(posedge clk);
		while (msg_ch.ready !== 1'b1) @(posedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic push_random(input logic [15:0] port, input logic signed [31:0] tag);
		push_msg(port, tag, rand_stamp(1'b1), rand_stamp(1'b0), rand_stamp(1'b0),
			rand_stamp(1'b1), rand_stamp(1'b0), rand_stamp(1'b1));
	endtask

	task automatic push_noise();
		push_random(cur_port ^ 16'($urandom_range(1, 65535)), $urandom);
	endtask

	// mostly complete sync sequences, some cut short by a random final tag, with messages from other ports mixed in
	task automatic rand_burst(inout int counted);
		int kind;
		int n;
		logic signed [31:0] tag;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			push_noise();
			return;
		end
		n = (kind < 72) ? 3 : $urandom_range(0, 2);
		for (int k = 1; k <= n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_noise();
			end
			push_random(cur_port, k);
			counted++;
		end
		if (kind >= 72) begin
			case ($urandom_range(0, 3))
				0: tag = corner_word();
				1: tag = $urandom;
				2: tag = $urandom_range(0, 4);
				default: tag = n;
			endcase
			push_random(cur_port, tag);
			counted++;
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic set_sync_port(input logic [15:0] p);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_port = p;
	endtask

	initial begin
		int counted;
		logic [15:0] p;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		msg_ch.valid <= 1'b0;
		msg_ch.source_port <= '0;
		msg_ch.seq_tag <= '0;
		msg_ch.word_low <= '0;
		msg_ch.word_high <= '0;
		msg_ch.rx_sec <= '0;
		msg_ch.rx_nsec <= '0;
		msg_ch.tx_sec <= '0;
		msg_ch.tx_nsec <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// other port, then a tag mismatch from idle
		push_msg(SYNC_PORT_RESET + 16'd1, STEP_RX, 0, 0, 0, 0, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_IDLE, 0, 0, 0, 0, 0, 0);
		// plain sequence
		push_msg(SYNC_PORT_RESET, STEP_RX, 0, 0, 5, 100, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_TX, 999_999_999, 3, 0, 0, 6, 0);
		push_msg(SYNC_PORT_RESET, STEP_ADJ, 500, 8, 0, 0, 0, 0);
		// borrow in both directions, other port in the middle
		push_msg(SYNC_PORT_RESET, STEP_RX, 0, 0, 0, 100, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_TX, 50, 1, 0, 0, 0, 10);
		push_msg(16'hffff, STEP_ADJ, 0, 0, 0, 0, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_ADJ, 5, 2, 0, 0, 0, 0);
		// extremes with wrap
		push_msg(SYNC_PORT_RESET, STEP_RX, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_TX, 32'h7fff_ffff, 32'h8000_0000, 0, 0,
			32'hffff_ffff, 32'hffff_ffff);
		push_msg(SYNC_PORT_RESET, STEP_ADJ, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0);
		// broken sequences
		push_msg(SYNC_PORT_RESET, STEP_RX, 0, 0, 1, 2, 3, 4);
		push_msg(SYNC_PORT_RESET, STEP_RX, 0, 0, 1, 2, 3, 4);
		push_msg(SYNC_PORT_RESET, STEP_ADJ, 0, 0, 0, 0, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_RX, 0, 0, 7, 7, 0, 0);
		push_msg(SYNC_PORT_RESET, STEP_TX, 1, 1, 0, 0, 2, 2);
		push_msg(SYNC_PORT_RESET, STEP_TX, 1, 1, 0, 0, 2, 2);
		// out of range tags
		push_msg(SYNC_PORT_RESET, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
		push_msg(SYNC_PORT_RESET, 4, 0, 0, 0, 0, 0, 0);
		push_msg(SYNC_PORT_RESET, -1, 0, 0, 0, 0, 0, 0);
		push_msg(SYNC_PORT_RESET, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
		push_msg(16'h0, STEP_RX, -1, -1, -1, -1, -1, -1);
		msg_ch.valid <= 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: p = 16'h0;
				1: p = 16'hffff;
				2: p = SYNC_PORT_RESET;
				default: p = 16'($urandom);
			endcase
			set_sync_port(p);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 69;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 69;
				end
				default: begin
					idle_pct = 11;
					stall_pct = 11;
				end
			endcase
			counted = 0;
			while (counted < 145) rand_burst(counted);
			msg_ch.valid <= 1'b0;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
